// ----- design/gsd_pkg.sv -----
// gsd_pkg: shared types and constants for the gear selector debounce reporter
// no dependencies

package gsd_pkg;

  typedef logic signed [3:0] gear_t;
  typedef logic [15:0]       age_t;
  typedef logic [1:0]        cfg_idx_t;

  localparam int unsigned PIN_COUNT = 7;
  localparam int unsigned CFG_W     = 16;

  localparam gear_t GEAR_NEUTRAL = 4'sd0;
  localparam gear_t GEAR_REVERSE = -4'sd1;
  localparam gear_t GEAR_MAX_FWD = 4'sd6;

  localparam age_t AGE_MAX = 16'hFFFF;

  // configuration register indexes
  localparam cfg_idx_t CFG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t CFG_REPORT   = 2'd1;
  localparam cfg_idx_t CFG_BLINK    = 2'd2;

  localparam age_t DEBOUNCE_RST = 16'd20;
  localparam age_t REPORT_RST   = 16'd100;
  localparam age_t BLINK_RST    = 16'd1000;

  typedef struct packed {
    age_t debounce_ticks;
    age_t report_period;
    age_t blink_period;
  } cfg_t;

  typedef struct packed {
    gear_t gear_code;
    logic  change_send;
    logic  periodic_send;
    logic  led_level;
  } result_t;

  function automatic age_t age_up(input age_t age);
    age_t r;
    r = (age == AGE_MAX) ? AGE_MAX : age + 16'd1;
    return r;
  endfunction

endpackage

// ----- design/gsd_decode.sv -----
// gsd_decode: maps seven active-low selector pins to a gear code
// depends on gsd_pkg

module gsd_decode (
  input  logic [gsd_pkg::PIN_COUNT-1:0] pins,
  output gsd_pkg::gear_t                gear
);
  import gsd_pkg::*;

  logic [PIN_COUNT-1:0] low;
  gear_t                pick;

  assign low = ~pins;

  // picks the gear of the highest low pin; only used when exactly one is low
  always_comb begin
    pick = GEAR_NEUTRAL;
    for (int i = 0; i < PIN_COUNT; i++) begin
      if (low[i]) begin
        if (i == PIN_COUNT - 1) begin
          pick = GEAR_REVERSE;
        end else begin
          pick = gear_t'(i + 1);
        end
      end
    end
  end

  assign gear = ($onehot(low)) ? pick : GEAR_NEUTRAL;

endmodule

// ----- design/gsd_tracker.sv -----
// gsd_tracker: debounce, report and heartbeat state, one update per tick
// depends on gsd_pkg

module gsd_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  gsd_pkg::gear_t    gear,
  input  gsd_pkg::cfg_t     cfg,
  output gsd_pkg::result_t  result
);
  import gsd_pkg::*;

  logic  started_r, started_nxt;
  gear_t raw_gear_r, raw_gear_nxt;
  gear_t stable_gear_r, stable_gear_nxt;
  gear_t reported_gear_r, reported_gear_nxt;
  age_t  raw_age_r, raw_age_nxt;
  age_t  report_age_r, report_age_nxt;
  age_t  blink_age_r, blink_age_nxt;
  logic  led_r, led_nxt;
  logic  change, periodic;

  always_comb begin
    age_t raw_inc, rep_inc, blk_inc;
    raw_inc = age_up(raw_age_r);
    rep_inc = age_up(report_age_r);
    blk_inc = age_up(blink_age_r);

    started_nxt       = 1'b1;
    raw_gear_nxt      = raw_gear_r;
    stable_gear_nxt   = stable_gear_r;
    reported_gear_nxt = reported_gear_r;
    raw_age_nxt       = raw_inc;
    report_age_nxt    = rep_inc;
    change            = 1'b0;
    periodic          = 1'b0;

    // heartbeat runs the same on every tick
    if (blk_inc >= cfg.blink_period) begin
      led_nxt       = ~led_r;
      blink_age_nxt = '0;
    end else begin
      led_nxt       = led_r;
      blink_age_nxt = blk_inc;
    end

    if (!started_r) begin
      raw_gear_nxt      = gear;
      stable_gear_nxt   = gear;
      reported_gear_nxt = gear;
      raw_age_nxt       = '0;
      report_age_nxt    = '0;
      change            = 1'b1;
    end else begin
      if (gear != raw_gear_r) begin
        raw_gear_nxt = gear;
        raw_age_nxt  = '0;
      end
      if (stable_gear_r != raw_gear_nxt && raw_age_nxt >= cfg.debounce_ticks) begin
        stable_gear_nxt = raw_gear_nxt;
      end
      if (stable_gear_nxt != reported_gear_r) begin
        change            = 1'b1;
        reported_gear_nxt = stable_gear_nxt;
      end
      if (rep_inc >= cfg.report_period) begin
        periodic       = 1'b1;
        report_age_nxt = '0;
      end
    end
  end

  assign result.gear_code     = stable_gear_nxt;
  assign result.change_send   = change;
  assign result.periodic_send = periodic;
  assign result.led_level     = led_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r       <= 1'b0;
      raw_gear_r      <= GEAR_NEUTRAL;
      stable_gear_r   <= GEAR_NEUTRAL;
      reported_gear_r <= GEAR_NEUTRAL;
      raw_age_r       <= '0;
      report_age_r    <= '0;
      blink_age_r     <= '0;
      led_r           <= 1'b1;
    end else if (step) begin
      started_r       <= started_nxt;
      raw_gear_r      <= raw_gear_nxt;
      stable_gear_r   <= stable_gear_nxt;
      reported_gear_r <= reported_gear_nxt;
      raw_age_r       <= raw_age_nxt;
      report_age_r    <= report_age_nxt;
      blink_age_r     <= blink_age_nxt;
      led_r           <= led_nxt;
    end
  end

endmodule

// ----- design/gear_selector_debounce_reporter.sv -----
// gear_selector_debounce_reporter: top level, input register, config and result register
// depends on gsd_pkg, gsd_decode, gsd_tracker
//
//   channel | ports                                         | transfer when
//   in      | in_valid, in_stall, in_pin_levels             | in_valid && !in_stall
//   out     | out_valid, out_stall, out_gear_code, out_*    | out_valid && !out_stall
//   cfg     | cfg_we, cfg_index, cfg_data                   | cfg_we
//
// one tick per cycle sustained while out_stall is low.
// the tick goes input register -> decode and tracker update -> result register.
// reset clears the gear state and the ages and sets the config to its defaults; LED starts on.
// a stalled result holds the pipe; in_stall rises only while the result register is full.

module gear_selector_debounce_reporter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gsd_pkg::PIN_COUNT-1:0] in_pin_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [3:0]             out_gear_code,
  output logic                          out_change_send,
  output logic                          out_periodic_send,
  output logic                          out_led_level,
  input  logic                          cfg_we,
  input  gsd_pkg::cfg_idx_t             cfg_index,
  input  logic [gsd_pkg::CFG_W-1:0]     cfg_data
);
  import gsd_pkg::*;

  cfg_t                 cfg_r;
  logic                 s1_valid_r;
  logic [PIN_COUNT-1:0] s1_pins_r;
  logic                 out_valid_r;
  result_t              out_r;
  logic                 step;
  gear_t                gear;
  result_t              result;

  // stage 1 moves on when the result register is empty or being taken
  assign step     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
      cfg_r.report_period  <= REPORT_RST;
      cfg_r.blink_period   <= BLINK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_data;
        CFG_REPORT:   cfg_r.report_period  <= cfg_data;
        CFG_BLINK:    cfg_r.blink_period   <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pins_r <= in_pin_levels;
    end
  end

  gsd_decode u_decode (
    .pins (s1_pins_r),
    .gear (gear)
  );

  gsd_tracker u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .gear   (gear),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gear_code     = out_r.gear_code;
  assign out_change_send   = out_r.change_send;
  assign out_periodic_send = out_r.periodic_send;
  assign out_led_level     = out_r.led_level;

endmodule

// ----- design/gsd_checker.sv -----
// gsd_checker: port-level checks for the gear selector debounce reporter
// depends on gsd_pkg; bound to gear_selector_debounce_reporter

module gsd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [gsd_pkg::PIN_COUNT-1:0] in_pin_levels,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [3:0]             out_gear_code,
  input logic                          out_change_send,
  input logic                          out_periodic_send,
  input logic                          out_led_level
);
  import gsd_pkg::*;

  // a stalled input offer stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_pin_levels))
    else $error("stalled input changed");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gear_code)
      && $stable(out_change_send) && $stable(out_periodic_send) && $stable(out_led_level))
    else $error("stalled result changed");

  // input backs up only behind a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gear_code <= GEAR_MAX_FWD && out_gear_code >= GEAR_REVERSE))
    else $error("gear code out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

endmodule

bind gear_selector_debounce_reporter gsd_checker u_gsd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_pin_levels     (in_pin_levels),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_gear_code     (out_gear_code),
  .out_change_send   (out_change_send),
  .out_periodic_send (out_periodic_send),
  .out_led_level     (out_led_level)
);
